FILE: hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier: command and
// event codes, register indexes, reset values and the compare unit records.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int PIN_W   = 8;
    localparam int LVL_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int EVB_W   = 3;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SINGLE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOLD       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HOLD_CLICK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd2;

    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd250;
    localparam logic [CFG_W-1:0] HOLD_REPEAT_RST   = 16'd250;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd20;

    typedef struct packed {
        logic [EVB_W-1:0]  button;
        logic [KIND_W-1:0] kind;
    } event_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [CFG_W-1:0]  thr;
    } alu_req_t;

    typedef struct packed {
        logic a_lt_b;
        logic diff_lt_thr;
        logic diff_gt_thr;
    } alu_rsp_t;

endpackage

FILE: hw/rtl/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies presses of active-low buttons into single, double, hold and
// hold-click events, queued for a host to pop.
// ----------------------------------------------------------------------------
// usage
//   s_ beats carry one command: pin edge, tick scan or pop. only a pop beat
//   produces an m_ beat, holding one event or the empty marker.
//   a pop beat is answered in the cycle after it is taken; the m_ side has an
//   output register, so a pending result holds while m_tready is low and
//   s_tready stays low for every command until that result beat is taken.
//   an edge beat passes state E0, and E1 for an accepted press. a tick beat
//   steps a sequencer over the buttons with one shared subtract/compare unit:
//   a button not waiting passes T0 only, one raising a hold-click and a hold
//   passes T0, T1, T3, T4 and T5. s_tready is low while the sequencer runs.
//   reset clears all time stamps, the waiting mask, the queue and loads the
//   register defaults (250, 250, 20 ms); there is no clearing pass.
//   registers are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int BUTTONS     = 8,
    parameter int QUEUE_DEPTH = 3
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cmd, now_ms, edge_pin, edge_value, pin_levels, zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // event_valid, event_button, event_kind, zero pad
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int BTN_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_E0   = 4'd1;
    localparam logic [3:0] ST_E1   = 4'd2;
    localparam logic [3:0] ST_T0   = 4'd3;
    localparam logic [3:0] ST_T1   = 4'd4;
    localparam logic [3:0] ST_T2   = 4'd5;
    localparam logic [3:0] ST_T3   = 4'd6;
    localparam logic [3:0] ST_T4   = 4'd7;
    localparam logic [3:0] ST_T5   = 4'd8;

    logic [CMD_W-1:0]  in_cmd;
    logic [TIME_W-1:0] in_now;
    logic [PIN_W-1:0]  in_pin;
    logic              in_value;
    logic [LVL_W-1:0]  in_levels;

    assign in_cmd    = s_tdata[1:0];
    assign in_now    = s_tdata[33:2];
    assign in_pin    = s_tdata[41:34];
    assign in_value  = s_tdata[42];
    assign in_levels = s_tdata[50:43];

    logic [3:0]        state_reg, state_next;
    logic [BTN_W-1:0]  btn_reg, btn_next;
    logic              pin_ok_reg, pin_ok_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              value_reg, value_next;
    logic [LVL_W-1:0]  levels_reg, levels_next;

    logic [CFG_W-1:0]  dwin_reg, dwin_next;
    logic [CFG_W-1:0]  hrep_reg, hrep_next;
    logic [CFG_W-1:0]  deb_reg, deb_next;

    logic [TIME_W-1:0] press_reg [BUTTONS];
    logic [TIME_W-1:0] press_next [BUTTONS];
    logic [TIME_W-1:0] release_reg [BUTTONS];
    logic [TIME_W-1:0] release_next [BUTTONS];
    logic [TIME_W-1:0] hold_reg [BUTTONS];
    logic [TIME_W-1:0] hold_next [BUTTONS];
    logic [BUTTONS-1:0] waiting_reg, waiting_next;
    logic [TIME_W-1:0] last_edge_reg, last_edge_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              ev_valid_reg, ev_valid_next;
    event_t            ev_reg, ev_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic              push_en, pop_en;
    event_t            push_data, head_data;
    logic              fifo_full, fifo_empty;
    logic              s_acc, last_btn;

    bcc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    bcc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_data (push_data),
        .pop_en    (pop_en),
        .head_data (head_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;
    assign last_btn = btn_reg == BTN_W'(BUTTONS - 1);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, ev_reg.kind, ev_reg.button, ev_valid_reg};

    // operand select for the shared compare unit
    always_comb begin
        alu_req.a   = now_reg;
        alu_req.b   = press_reg[btn_reg];
        alu_req.thr = dwin_reg;
        unique case (state_reg)
            ST_E0: begin
                alu_req.b   = last_edge_reg;
                alu_req.thr = deb_reg;
            end
            ST_T1: begin
                alu_req.a = press_reg[btn_reg];
                alu_req.b = release_reg[btn_reg];
            end
            ST_T2: begin
                alu_req.a = hold_reg[btn_reg];
                alu_req.b = press_reg[btn_reg];
            end
            ST_T3: begin
                alu_req.b   = hold_reg[btn_reg];
                alu_req.thr = hrep_reg;
            end
            ST_T4: begin
                alu_req.a = release_reg[btn_reg];
                alu_req.b = hold_reg[btn_reg];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        btn_next       = btn_reg;
        pin_ok_next    = pin_ok_reg;
        now_next       = now_reg;
        value_next     = value_reg;
        levels_next    = levels_reg;
        dwin_next      = dwin_reg;
        hrep_next      = hrep_reg;
        deb_next       = deb_reg;
        press_next     = press_reg;
        release_next   = release_reg;
        hold_next      = hold_reg;
        waiting_next   = waiting_reg;
        last_edge_next = last_edge_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        ev_valid_next  = ev_valid_reg;
        ev_next        = ev_reg;
        push_en        = 1'b0;
        push_data.button = EVB_W'(btn_reg);
        push_data.kind   = KIND_SINGLE;
        pop_en         = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_DOUBLE_WINDOW: dwin_next = cfg_data;
                REG_HOLD_REPEAT:   hrep_next = cfg_data;
                REG_DEBOUNCE:      deb_next  = cfg_data;
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    now_next    = in_now;
                    value_next  = in_value;
                    levels_next = in_levels;
                    unique case (in_cmd)
                        CMD_EDGE: begin
                            btn_next    = in_pin[BTN_W-1:0];
                            pin_ok_next = in_pin < PIN_W'(BUTTONS);
                            state_next  = ST_E0;
                        end
                        CMD_TICK: begin
                            btn_next   = '0;
                            state_next = ST_T0;
                        end
                        CMD_POP: begin
                            pop_en        = 1'b1;
                            m_tvalid_next = 1'b1;
                            ev_valid_next = !fifo_empty;
                            ev_next       = fifo_empty ? '0 : head_data;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_E0: begin
                last_edge_next = now_reg;
                state_next     = ST_IDLE;
                if (alu_rsp.diff_gt_thr && pin_ok_reg) begin
                    if (!value_reg) begin
                        state_next = ST_E1;
                    end else begin
                        release_next[btn_reg] = now_reg;
                    end
                end
            end
            ST_E1: begin
                if (alu_rsp.diff_lt_thr) begin
                    push_en                = 1'b1;
                    push_data.kind         = KIND_DOUBLE;
                    waiting_next[btn_reg]  = 1'b0;
                end else begin
                    waiting_next[btn_reg]  = 1'b1;
                end
                press_next[btn_reg] = now_reg;
                state_next          = ST_IDLE;
            end
            ST_T0: begin
                if (!waiting_reg[btn_reg] || alu_rsp.diff_lt_thr) begin
                    state_next = last_btn ? ST_IDLE : ST_T0;
                    btn_next   = last_btn ? btn_reg : btn_reg + 1'b1;
                end else begin
                    state_next = ST_T1;
                end
            end
            ST_T1: begin
                state_next = alu_rsp.a_lt_b ? ST_T2 : ST_T3;
            end
            ST_T2: begin
                if (alu_rsp.a_lt_b) begin
                    push_en               = 1'b1;
                    push_data.kind        = KIND_SINGLE;
                    waiting_next[btn_reg] = 1'b0;
                end
                state_next = last_btn ? ST_IDLE : ST_T0;
                btn_next   = last_btn ? btn_reg : btn_reg + 1'b1;
            end
            ST_T3: begin
                if (!alu_rsp.diff_lt_thr && !levels_reg[btn_reg]) begin
                    state_next = ST_T4;
                end else begin
                    state_next = last_btn ? ST_IDLE : ST_T0;
                    btn_next   = last_btn ? btn_reg : btn_reg + 1'b1;
                end
            end
            ST_T4: begin
                // hold stamp not after release: first hold of this press
                if (!alu_rsp.a_lt_b) begin
                    push_en        = 1'b1;
                    push_data.kind = KIND_HOLD_CLICK;
                end
                state_next = ST_T5;
            end
            ST_T5: begin
                push_en            = 1'b1;
                push_data.kind     = KIND_HOLD;
                hold_next[btn_reg] = now_reg;
                state_next = last_btn ? ST_IDLE : ST_T0;
                btn_next   = last_btn ? btn_reg : btn_reg + 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            btn_reg       <= '0;
            pin_ok_reg    <= 1'b0;
            dwin_reg      <= DOUBLE_WINDOW_RST;
            hrep_reg      <= HOLD_REPEAT_RST;
            deb_reg       <= DEBOUNCE_RST;
            waiting_reg   <= '0;
            last_edge_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < BUTTONS; i++) begin
                press_reg[i]   <= '0;
                release_reg[i] <= '0;
                hold_reg[i]    <= '0;
            end
        end else begin
            state_reg     <= state_next;
            btn_reg       <= btn_next;
            pin_ok_reg    <= pin_ok_next;
            dwin_reg      <= dwin_next;
            hrep_reg      <= hrep_next;
            deb_reg       <= deb_next;
            waiting_reg   <= waiting_next;
            last_edge_reg <= last_edge_next;
            m_tvalid_reg  <= m_tvalid_next;
            press_reg     <= press_next;
            release_reg   <= release_next;
            hold_reg      <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        value_reg    <= value_next;
        levels_reg   <= levels_next;
        ev_valid_reg <= ev_valid_next;
        ev_reg       <= ev_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && in_cmd == CMD_TICK |=> state_reg == ST_T0 && btn_reg == '0)
        else $error("tick scan did not start at the first button");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && in_cmd == CMD_POP |=> m_tvalid)
        else $error("pop beat produced no result beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_T2 && alu_rsp.a_lt_b |=> !waiting_reg[$past(btn_reg)])
        else $error("single left the button waiting");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("input taken while sequencer busy");

endmodule

FILE: hw/rtl/bcc_alu.sv
// ----------------------------------------------------------------------------
// bcc_alu
// Shared time compare unit: one 32-bit subtract giving a - b modulo 2^32,
// the unsigned order of a and b, and the difference against a threshold.
// ----------------------------------------------------------------------------
module bcc_alu
    import bcc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [TIME_W:0]   sub;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] thr_ext;

    assign sub     = {1'b0, req.a} - {1'b0, req.b};
    assign diff    = sub[TIME_W-1:0];
    assign thr_ext = TIME_W'(req.thr);

    assign rsp.a_lt_b      = sub[TIME_W];
    assign rsp.diff_lt_thr = diff < thr_ext;
    assign rsp.diff_gt_thr = diff > thr_ext;

endmodule

FILE: hw/rtl/bcc_fifo.sv
// ----------------------------------------------------------------------------
// bcc_fifo
// Small event queue with head and tail pointers and a fill count; a push
// into a full queue is dropped.
// ----------------------------------------------------------------------------
module bcc_fifo
    import bcc_pkg::*;
#(
    parameter int DEPTH = 3
)(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_en,
    input  event_t push_data,
    input  logic   pop_en,
    output event_t head_data,
    output logic   full,
    output logic   empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    event_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign head_data = mem_reg[head_reg];
    assign do_push   = push_en && !full;
    assign do_pop    = pop_en && !empty;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push) begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop) begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[tail_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("event queue count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push_en && full && !pop_en |=> $stable(count_reg))
        else $error("push into full queue changed the count");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_click_classifier. A driver feeds edge, tick,
// pop and unused-command beats from a queue; a tracker of the click logic
// predicts every pop result; a monitor checks each result beat in order.
// Timing registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import bcc_pkg::*;

    localparam int BUTTONS     = 8;
    localparam int QUEUE_DEPTH = 3;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_BEATS   = 285;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam logic                 PIN_PRESSED  = 1'b0;
    localparam logic                 PIN_RELEASED = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_ms;
        logic [PIN_W-1:0]  pin;
        logic              pin_value;
        logic [LVL_W-1:0]  levels;
    } beat_t;

    typedef struct packed {
        logic              valid;
        logic [EVB_W-1:0]  button;
        logic [KIND_W-1:0] kind;
    } pop_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    button_click_classifier #(
        .BUTTONS     (BUTTONS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // tracked state of the classifier
    logic [CFG_W-1:0]   win_ms;
    logic [CFG_W-1:0]   rep_ms;
    logic [CFG_W-1:0]   deb_ms;
    logic [TIME_W-1:0]  press_at   [BUTTONS];
    logic [TIME_W-1:0]  release_at [BUTTONS];
    logic [TIME_W-1:0]  hold_at    [BUTTONS];
    logic [BUTTONS-1:0] waiting;
    logic [TIME_W-1:0]  last_edge_ms;
    event_t             queued_events [$];

    pop_t        pops_due [$];
    beat_t       pending  [$];
    beat_t       on_bus;
    logic [31:0] gen_ms;
    int unsigned beats_queued = 0;
    int unsigned beats_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned kinds_seen [4] = '{0, 0, 0, 0};
    int unsigned settings_run = 1;

    function automatic void enqueue_event(int unsigned b, logic [KIND_W-1:0] k);
        event_t ev;
        ev.button = b[EVB_W-1:0];
        ev.kind   = k;
        if (queued_events.size() < QUEUE_DEPTH)
            queued_events.push_back(ev);
        if (k == KIND_SINGLE)
            waiting[b] = 1'b0;
    endfunction

    function automatic void gesture_step(beat_t bt);
        logic [TIME_W-1:0] dt;
        int unsigned       p;
        event_t            ev;
        pop_t              res;
        case (bt.cmd)
            CMD_EDGE: begin
                dt = bt.now_ms - last_edge_ms;
                if (dt > deb_ms && bt.pin < BUTTONS) begin
                    p = 32'(bt.pin);
                    if (bt.pin_value == PIN_PRESSED) begin
                        dt = bt.now_ms - press_at[p];
                        if (dt < win_ms) begin
                            enqueue_event(p, KIND_DOUBLE);
                            waiting[p] = 1'b0;
                        end else begin
                            waiting[p] = 1'b1;
                        end
                        press_at[p] = bt.now_ms;
                    end else begin
                        release_at[p] = bt.now_ms;
                    end
                end
                last_edge_ms = bt.now_ms;
            end
            CMD_TICK: begin
                for (int i = 0; i < BUTTONS; i++) begin
                    dt = bt.now_ms - press_at[i];
                    if (waiting[i] && dt >= win_ms) begin
                        if (press_at[i] < release_at[i]) begin
                            if (hold_at[i] < press_at[i])
                                enqueue_event(i, KIND_SINGLE);
                        end else begin
                            dt = bt.now_ms - hold_at[i];
                            if (dt >= rep_ms && !bt.levels[i]) begin
                                if (hold_at[i] <= release_at[i])
                                    enqueue_event(i, KIND_HOLD_CLICK);
                                enqueue_event(i, KIND_HOLD);
                                hold_at[i] = bt.now_ms;
                            end
                        end
                    end
                end
            end
            CMD_POP: begin
                res = '0;
                if (queued_events.size() != 0) begin
                    ev = queued_events.pop_front();
                    res.valid  = 1'b1;
                    res.button = ev.button;
                    res.kind   = ev.kind;
                end
                pops_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // sender
    int unsigned send_gap  = 0;
    int unsigned send_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                gesture_step(on_bus);
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    on_bus = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_DATA_W-51){1'b0}}, on_bus.levels, on_bus.pin_value,
                                 on_bus.pin, on_bus.now_ms, on_bus.cmd};
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = idle_len();
                        if ($urandom_range(0, 49) == 0)
                            send_calm = $urandom_range(20, 120);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off now and then so the input backs up
    int unsigned take_gap  = 0;
    int unsigned take_calm = 0;
    int unsigned hold_off  = 0;
    int unsigned rx_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 8000 == 1500)
                hold_off = 400;
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (take_calm > 0) begin
                    take_calm--;
                end else begin
                    take_gap = idle_len();
                    if ($urandom_range(0, 39) == 0)
                        take_calm = $urandom_range(20, 150);
                end
            end
        end
    end

    // result checker
    pop_t got_pop;
    pop_t want_pop;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_pop = {m_tdata[0], m_tdata[3:1], m_tdata[5:4]};
            results_seen++;
            if (got_pop.valid)
                kinds_seen[got_pop.kind]++;
            if (pops_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: valid %0d button %0d kind %0d",
                             got_pop.valid, got_pop.button, got_pop.kind);
            end else begin
                want_pop = pops_due.pop_front();
                if (got_pop !== want_pop) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pop result %0d: expected valid %0d button %0d kind %0d,",
                                  " got valid %0d button %0d kind %0d"},
                                 results_seen, want_pop.valid, want_pop.button,
                                 want_pop.kind, got_pop.valid, got_pop.button, got_pop.kind);
                end
            end
        end
    end

    task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                            input logic [PIN_W-1:0] pin, input logic val,
                            input logic [LVL_W-1:0] lvl);
        beat_t bt;
        bt.cmd       = cmd;
        bt.now_ms    = now;
        bt.pin       = pin;
        bt.pin_value = val;
        bt.levels    = lvl;
        pending.push_back(bt);
        beats_queued++;
    endtask

    task automatic step_edge(input int unsigned b, input logic val);
        gen_ms = gen_ms + deb_ms + 1 + $urandom_range(0, 40);
        add_item(CMD_EDGE, gen_ms, PIN_W'(b), val, LVL_W'($urandom));
    endtask

    task automatic tick_at(input logic [TIME_W-1:0] t, input logic [LVL_W-1:0] lvl);
        add_item(CMD_TICK, t, PIN_W'($urandom), 1'($urandom), lvl);
        if ((t - gen_ms) < 32'h8000_0000)
            gen_ms = t;
    endtask

    task automatic add_pops(input int unsigned n);
        for (int i = 0; i < n; i++)
            add_item(CMD_POP, gen_ms, PIN_W'($urandom), 1'($urandom), LVL_W'($urandom));
    endtask

    task automatic add_gesture();
        int unsigned       b;
        int unsigned       pick;
        int unsigned       n;
        logic [TIME_W-1:0] pressed_ms;
        logic [TIME_W-1:0] t;
        logic [LVL_W-1:0]  lvl;
        b    = $urandom_range(0, BUTTONS - 1);
        pick = $urandom_range(0, 99);
        // occasional bounce inside the debounce time
        if ($urandom_range(0, 9) == 0) begin
            gen_ms = gen_ms + $urandom_range(0, deb_ms);
            add_item(CMD_EDGE, gen_ms, PIN_W'(b), 1'($urandom), LVL_W'($urandom));
        end
        if (pick < 8) begin
            gen_ms = $urandom;
            add_item(CMD_W'($urandom_range(0, 3)), gen_ms, PIN_W'($urandom), 1'($urandom),
                     LVL_W'($urandom));
        end else if (pick < 38) begin
            step_edge(b, PIN_PRESSED);
            pressed_ms = gen_ms;
            step_edge(b, PIN_RELEASED);
            lvl = LVL_W'($urandom);
            lvl[b] = 1'b1;
            tick_at(pressed_ms + win_ms + $urandom_range(0, 30), lvl);
            add_pops($urandom_range(0, 3) == 0 ? 0 : 1);
        end else if (pick < 62) begin
            step_edge(b, PIN_PRESSED);
            step_edge(b, PIN_RELEASED);
            step_edge(b, PIN_PRESSED);
            step_edge(b, PIN_RELEASED);
            if ($urandom_range(0, 1))
                tick_at(gen_ms + win_ms + $urandom_range(0, 30), LVL_W'($urandom));
            add_pops($urandom_range(0, 2));
        end else if (pick < 88) begin
            step_edge(b, PIN_PRESSED);
            pressed_ms = gen_ms;
            n = $urandom_range(1, 4);
            t = pressed_ms + win_ms;
            for (int k = 0; k < n; k++) begin
                if (k != 0)
                    t = t + ($urandom_range(0, 3) == 0 ? rep_ms / 2 : rep_ms);
                t = t + $urandom_range(0, 20);
                lvl = LVL_W'($urandom);
                lvl[b] = ($urandom_range(0, 9) == 0);
                tick_at(t, lvl);
            end
            step_edge(b, PIN_RELEASED);
            tick_at(gen_ms + $urandom_range(0, 30), LVL_W'($urandom));
            add_pops($urandom_range(0, 3));
        end else begin
            add_pops($urandom_range(1, 4));
        end
    endtask

    task automatic drain();
        do
            @(posedge aclk);
        while (pending.size() != 0 || s_tvalid || pops_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DOUBLE_WINDOW: win_ms = val;
            REG_HOLD_REPEAT:   rep_ms = val;
            REG_DEBOUNCE:      deb_ms = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] rep,
                             input logic [CFG_W-1:0] deb);
        write_reg(REG_DOUBLE_WINDOW, win);
        write_reg(REG_HOLD_REPEAT, rep);
        write_reg(REG_DEBOUNCE, deb);
        settings_run++;
        beats_queued = 0;
        while (beats_queued < PHASE_BEATS)
            add_gesture();
        drain();
    endtask

    initial begin
        win_ms       = DOUBLE_WINDOW_RST;
        rep_ms       = HOLD_REPEAT_RST;
        deb_ms       = DEBOUNCE_RST;
        waiting      = '0;
        last_edge_ms = '0;
        gen_ms       = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            press_at[i]   = '0;
            release_at[i] = '0;
            hold_at[i]    = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, unused command, stray pin, bounce
        add_item(CMD_POP, 32'd0, 8'd0, 1'b0, 8'hFF);
        add_item(CMD_UNUSED, '1, '1, 1'b1, '1);
        add_item(CMD_EDGE, 32'd100, 8'd255, PIN_RELEASED, 8'h00);
        add_item(CMD_EDGE, 32'd110, 8'd0, PIN_PRESSED, 8'hFF);
        // single on button 0
        add_item(CMD_EDGE, 32'd1000, 8'd0, PIN_PRESSED, 8'hFE);
        add_item(CMD_EDGE, 32'd1050, 8'd0, PIN_RELEASED, 8'hFF);
        add_item(CMD_TICK, 32'd1100, 8'd0, 1'b0, 8'hFF);
        add_item(CMD_TICK, 32'd1300, 8'd0, 1'b0, 8'hFF);
        add_item(CMD_POP, 32'd1310, 8'd0, 1'b0, 8'hFF);
        // double on button 1
        add_item(CMD_EDGE, 32'd2000, 8'd1, PIN_PRESSED, 8'hFD);
        add_item(CMD_EDGE, 32'd2100, 8'd1, PIN_RELEASED, 8'hFF);
        add_item(CMD_EDGE, 32'd2200, 8'd1, PIN_PRESSED, 8'hFD);
        add_item(CMD_EDGE, 32'd2300, 8'd1, PIN_RELEASED, 8'hFF);
        add_item(CMD_POP, 32'd2310, 8'd0, 1'b0, 8'hFF);
        // hold on button 7 until the queue overflows, then release after hold
        add_item(CMD_EDGE, 32'd3000, 8'd7, PIN_PRESSED, 8'h7F);
        add_item(CMD_TICK, 32'd3300, 8'd0, 1'b0, 8'h7F);
        add_item(CMD_TICK, 32'd3600, 8'd0, 1'b0, 8'h7F);
        add_item(CMD_TICK, 32'd3900, 8'd0, 1'b0, 8'h7F);
        add_item(CMD_EDGE, 32'd4000, 8'd7, PIN_RELEASED, 8'hFF);
        add_item(CMD_TICK, 32'd4300, 8'd0, 1'b0, 8'hFF);
        add_pops(3);
        // time stamps across the wrap
        add_item(CMD_EDGE, 32'hFFFF_FFF0, 8'd2, PIN_PRESSED, 8'hFB);
        add_item(CMD_TICK, 32'h0000_0100, 8'd0, 1'b0, 8'h00);
        add_item(CMD_POP, 32'h0000_0110, 8'd0, 1'b0, 8'h00);
        add_item(CMD_EDGE, 32'hFFFF_FFFF, 8'd8, PIN_RELEASED, 8'hFF);
        drain();

        gen_ms = 32'd10000;
        beats_queued = 0;
        while (beats_queued < PHASE_BEATS)
            add_gesture();
        drain();

        write_reg(REG_SPARE, 16'hFFFF);
        run_phase(16'd0, 16'd0, 16'd0);
        run_phase(16'hFFFF, 16'hFFFF, 16'd0);
        run_phase(16'd300, 16'd100, 16'hFFFF);
        run_phase(16'd120, 16'd40, 16'd10);

        $display("run: %0d beats taken under %0d timing settings, %0d pop results, %0d mismatches",
                 beats_taken, settings_run, results_seen, mismatches);
        $display("popped events: %0d single, %0d double, %0d hold, %0d hold-click",
                 kinds_seen[KIND_SINGLE], kinds_seen[KIND_DOUBLE], kinds_seen[KIND_HOLD],
                 kinds_seen[KIND_HOLD_CLICK]);
        if (mismatches == 0 && pops_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_alu.sv
hw/rtl/bcc_fifo.sv
hw/rtl/button_click_classifier.sv
tb/sv/tb.sv
